// ===== hw/rtl/lfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsc_pkg
// Shared types and constants of the line-follow step controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsc_pkg;

  localparam int AngleW   = 14;
  localparam int OffsetW  = 11;
  localparam int HeadingW = 15;
  localparam int SpeedW   = 16;
  localparam int SideW    = 27;
  localparam int TurnW    = 24;
  localparam int CountW   = 8;
  localparam int DistW    = 40;
  localparam int LostW    = 6;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Heading math runs on 17-bit signed differences, 1/64 degree units.
  localparam int DiffW = HeadingW + 2;
  localparam logic signed [DiffW-1:0] CornerAngle = 17'sd5440;   // 85 deg
  localparam logic signed [DiffW-1:0] HalfTurn    = 17'sd11520;  // 180 deg
  localparam logic signed [DiffW-1:0] FullTurn    = 17'sd23040;  // 360 deg

  localparam logic signed [TurnW-1:0] CornerTurnRate = 24'sd32768;  // 0.5 in Q.16
  localparam logic [LostW-1:0]        LostExit       = 6'd15;
  localparam logic [LostW-1:0]        LostStop       = 6'd30;

  // floor(3*c/10) == (c * SlowMul) >> SlowShift for every 16-bit c
  localparam int                SlowShift = 19;
  localparam logic [17:0]       SlowMul   = 18'd157287;

  // Reset values of the configuration registers
  localparam logic [3:0]          ExitEnRst   = 4'd0;
  localparam logic [CountW-1:0]   TargetRst   = 8'd4;
  localparam logic [SpeedW-1:0]   CruiseRst   = 16'd13107;
  localparam logic [SpeedW-1:0]   HGainRst    = 16'd3277;
  localparam logic [SpeedW-1:0]   OGainRst    = 16'd197;

  // exit_enables bit positions
  localparam int ExitObstacle = 0;
  localparam int ExitRed      = 1;
  localparam int ExitLost     = 2;
  localparam int ExitCorner   = 3;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_MOVE      = 2'd1,
    CMD_FREE_WALK = 2'd2,
    CMD_STOP      = 2'd3
  } drive_cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EXIT_EN  = 3'd0,
    REG_TARGET   = 3'd1,
    REG_CRUISE   = 3'd2,
    REG_HGAIN    = 3'd3,
    REG_OGAIN    = 3'd4
  } cfg_reg_t;

  // Steering products handed from the arithmetic unit to the control logic
  typedef struct packed {
    logic [SpeedW-1:0]       slow_speed;
    logic signed [SideW-1:0] side;
    logic signed [TurnW-1:0] turn;
  } steer_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfsc_steer.sv =====
// ----------------------------------------------------------------------------
// lfsc_steer
// Steering arithmetic: turn rate and side speed from the line, slow speed.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_steer (
  input  var logic signed [lfsc_pkg::AngleW-1:0]  line_angle,
  input  var logic signed [lfsc_pkg::OffsetW-1:0] line_offset,
  input  var logic [lfsc_pkg::SpeedW-1:0]         cruise_speed,
  input  var logic [lfsc_pkg::SpeedW-1:0]         heading_gain,
  input  var logic [lfsc_pkg::SpeedW-1:0]         offset_gain,
  output lfsc_pkg::steer_t                        steer
);
  import lfsc_pkg::*;

  logic signed [30:0] angle_prod;
  logic signed [30:0] angle_adj;
  logic signed [24:0] angle_q;
  logic signed [25:0] turn_neg;
  logic signed [27:0] side_prod;
  logic [33:0]        slow_prod;

  // angle * gain / 64, truncated toward zero, then negated
  assign angle_prod = line_angle * $signed({1'b0, heading_gain});
  assign angle_adj  = angle_prod + (angle_prod[30] ? 31'sd63 : 31'sd0);
  assign angle_q    = angle_adj[30:6];
  assign turn_neg   = -$signed({angle_q[24], angle_q});

  assign side_prod  = line_offset * $signed({1'b0, offset_gain});
  assign slow_prod  = cruise_speed * SlowMul;

  always_comb begin
    if (turn_neg > 26'sd8388607) begin
      steer.turn = 24'sh7FFFFF;
    end else if (turn_neg < -26'sd8388608) begin
      steer.turn = 24'sh800000;
    end else begin
      steer.turn = turn_neg[TurnW-1:0];
    end

    if (side_prod > 28'sd67108863) begin
      steer.side = 27'sh3FFFFFF;
    end else if (side_prod < -28'sd67108864) begin
      steer.side = 27'sh4000000;
    end else begin
      steer.side = side_prod[SideW-1:0];
    end

    steer.slow_speed = {1'b0, slow_prod[33:SlowShift]};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/line_follow_step_controller.sv =====
// ----------------------------------------------------------------------------
// line_follow_step_controller
// Per-frame line-follow decision: exits, corner turns, steering, odometry.
// ----------------------------------------------------------------------------
// One input transfer per camera frame gives exactly one result transfer.
// The block takes a new frame every clock cycle while in_tready is high; a
// frame passes through the input register, then the result register,
// and the lost-frame counter, corner mode and distance sum are updated in
// the same cycle the result register loads, so back-to-back frames see
// each other's state. in_tready drops only when both the input register
// and the result register are full and out_tready is low. in_tuser carries
// frame_ok; with frame_ok low the state is left alone and the result shows
// drive command "none" with the current corner count and distance.
// Configuration writes are always taken (cfg_ready is tied high) and must
// happen while no frame is in flight. Angles are in 1/64 degree, speeds and
// gains in Q.16.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_step_controller (
  input  var logic         clk,
  input  var logic         rst_n,
  // input stream
  input  var logic         in_tvalid,
  output logic             in_tready,
  // [0] line_valid, [1] line_top_ok, [15:2] line_angle, [26:16] line_offset,
  // [41:27] heading, [42] obstacle_seen, [43] red_circle_seen, [47:44] zero
  input  var logic [47:0]  in_tdata,
  // [0] frame_ok
  input  var logic         in_tuser,
  // result stream
  output logic             out_tvalid,
  input  var logic         out_tready,
  // [0] leave, [16:1] fwd_speed, [43:17] side_speed, [67:44] turn_rate,
  // [75:68] corners_done, [115:76] distance_sum, [119:116] zero
  output logic [119:0]     out_tdata,
  // [1:0] drive_cmd
  output logic [1:0]       out_tuser,
  // configuration writes
  input  var logic         cfg_valid,
  output logic             cfg_ready,
  input  var logic [lfsc_pkg::CfgIdxW-1:0]  cfg_index,
  input  var logic [lfsc_pkg::CfgDataW-1:0] cfg_data
);
  import lfsc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [3:0]        exit_en_r;
  logic [CountW-1:0] target_r;
  logic [SpeedW-1:0] cruise_r;
  logic [SpeedW-1:0] hgain_r;
  logic [SpeedW-1:0] ogain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_en_r <= ExitEnRst;
      target_r  <= TargetRst;
      cruise_r  <= CruiseRst;
      hgain_r   <= HGainRst;
      ogain_r   <= OGainRst;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EXIT_EN: exit_en_r <= cfg_data[3:0];
        REG_TARGET:  target_r  <= cfg_data[CountW-1:0];
        REG_CRUISE:  cruise_r  <= cfg_data;
        REG_HGAIN:   hgain_r   <= cfg_data;
        REG_OGAIN:   ogain_r   <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid_r;
  logic out_valid_r;
  logic pipe_en;     // result register may load
  logic commit;      // frame in the input register moves to the result

  assign pipe_en   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || pipe_en;
  assign commit    = s1_valid_r && pipe_en;

  // ---------------- input register ----------------
  logic                       s1_frame_r;
  logic                       s1_line_valid_r;
  logic                       s1_top_ok_r;
  logic signed [AngleW-1:0]   s1_angle_r;
  logic signed [OffsetW-1:0]  s1_offset_r;
  logic signed [HeadingW-1:0] s1_heading_r;
  logic                       s1_obstacle_r;
  logic                       s1_red_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_frame_r      <= in_tuser;
      s1_line_valid_r <= in_tdata[0];
      s1_top_ok_r     <= in_tdata[1];
      s1_angle_r      <= in_tdata[15:2];
      s1_offset_r     <= in_tdata[26:16];
      s1_heading_r    <= in_tdata[41:27];
      s1_obstacle_r   <= in_tdata[42];
      s1_red_r        <= in_tdata[43];
    end
  end

  // ---------------- controller state ----------------
  logic [LostW-1:0]           lost_r, lost_nxt;
  logic                       cornering_r, cornering_nxt;
  logic signed [HeadingW-1:0] start_heading_r, start_heading_nxt;
  logic [CountW-1:0]          corner_total_r, corner_total_nxt;
  logic [DistW-1:0]           dist_r, dist_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lost_r          <= '0;
      cornering_r     <= 1'b0;
      start_heading_r <= '0;
      corner_total_r  <= '0;
      dist_r          <= '0;
    end else if (commit) begin
      lost_r          <= lost_nxt;
      cornering_r     <= cornering_nxt;
      start_heading_r <= start_heading_nxt;
      corner_total_r  <= corner_total_nxt;
      dist_r          <= dist_nxt;
    end
  end

  // ---------------- steering arithmetic ----------------
  steer_t steer;

  lfsc_steer u_steer (
    .line_angle   (s1_angle_r),
    .line_offset  (s1_offset_r),
    .cruise_speed (cruise_r),
    .heading_gain (hgain_r),
    .offset_gain  (ogain_r),
    .steer        (steer)
  );

  // ---------------- per-frame helpers ----------------
  logic [DistW:0]             dist_sum;
  logic [DistW-1:0]           dist_sat;
  logic [LostW-1:0]           lost_upd;
  logic                       start_now;
  logic                       corner_active;
  logic signed [HeadingW-1:0] base_heading;
  logic signed [DiffW-1:0]    diff, wrap_hi, wrap_lo, diff_mag;
  logic                       corner_reached;
  logic [CountW-1:0]          total_inc;

  // distance saturates at all ones
  assign dist_sum = {1'b0, dist_r} + (DistW+1)'(cruise_r);
  assign dist_sat = dist_sum[DistW] ? '1 : dist_sum[DistW-1:0];

  // lost counter: saturating increment on no line, clear on a line
  assign lost_upd = s1_line_valid_r ? '0 :
                    ((lost_r == '1) ? lost_r : lost_r + 1'b1);

  // corner begins on a valid line missing at the top of the image
  assign start_now     = !cornering_r && s1_line_valid_r && !s1_top_ok_r;
  assign corner_active = cornering_r || start_now;
  assign base_heading  = start_now ? s1_heading_r : start_heading_r;

  // heading change wrapped once each way into +-180 degrees
  assign diff    = DiffW'(s1_heading_r) - DiffW'(base_heading);
  assign wrap_hi = (diff > HalfTurn) ? diff - FullTurn : diff;
  assign wrap_lo = (wrap_hi < -HalfTurn) ? wrap_hi + FullTurn : wrap_hi;
  assign diff_mag = wrap_lo[DiffW-1] ? -wrap_lo : wrap_lo;
  assign corner_reached = diff_mag >= CornerAngle;

  assign total_inc = (corner_total_r == '1) ? corner_total_r : corner_total_r + 1'b1;

  // ---------------- decision ----------------
  logic                    res_leave;
  drive_cmd_t              res_cmd;
  logic [SpeedW-1:0]       res_fwd;
  logic signed [SideW-1:0] res_side;
  logic signed [TurnW-1:0] res_turn;
  logic                    corner_handled;

  always_comb begin
    lost_nxt          = lost_r;
    cornering_nxt     = cornering_r;
    start_heading_nxt = start_heading_r;
    corner_total_nxt  = corner_total_r;
    dist_nxt          = dist_r;
    res_leave         = 1'b0;
    res_cmd           = CMD_NONE;
    res_fwd           = '0;
    res_side          = '0;
    res_turn          = '0;
    corner_handled    = 1'b0;

    if (s1_frame_r) begin
      dist_nxt = dist_sat;
      priority if (exit_en_r[ExitObstacle] && s1_obstacle_r) begin
        res_leave = 1'b1;
      end else if (exit_en_r[ExitRed] && s1_red_r) begin
        res_leave = 1'b1;
      end else begin
        lost_nxt = lost_upd;
        if (exit_en_r[ExitLost] && (lost_upd > LostExit)) begin
          res_leave = 1'b1;
        end else begin
          if (exit_en_r[ExitCorner] && corner_active) begin
            corner_handled    = 1'b1;
            start_heading_nxt = base_heading;
            if (corner_reached) begin
              corner_total_nxt = total_inc;
              cornering_nxt    = 1'b0;
              res_cmd          = CMD_FREE_WALK;
              res_leave        = (total_inc >= target_r);
            end else begin
              cornering_nxt = 1'b1;
              res_cmd       = CMD_MOVE;
              res_fwd       = steer.slow_speed;
              res_turn      = CornerTurnRate;
            end
          end
          if (!corner_handled) begin
            priority if (!s1_line_valid_r) begin
              res_cmd = (lost_upd > LostStop) ? CMD_STOP : CMD_NONE;
            end else if (s1_top_ok_r) begin
              res_cmd  = CMD_MOVE;
              res_fwd  = cruise_r;
              res_turn = steer.turn;
              res_side = steer.side;
            end else begin
              // line runs out at the top: creep toward the corner
              res_cmd = CMD_MOVE;
              res_fwd = steer.slow_speed;
            end
          end
        end
      end
    end
  end

  // ---------------- result register ----------------
  logic [119:0] out_tdata_r;
  logic [1:0]   out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_tdata_r <= {4'b0, dist_nxt, corner_total_nxt, res_turn, res_side,
                      res_fwd, res_leave};
      out_tuser_r <= res_cmd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire
